/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the telemetry frame parser.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define EFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("efp assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define EFP_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("efp assertion failed");

`endif

/* sv/efp_pkg.sv */
// Package for the telemetry frame parser: constants, codes, frame and result types.
// No dependencies; every other file of the block but the assertion macros uses it by scoped names.
`timescale 1ns / 1ps

package efp_pkg;

  // Frame layout
  localparam int FRAME_LEN = 22;
  localparam int SUM_LEN   = 18;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_SUM  = POS_W'(SUM_LEN);
  localparam logic [7:0] STOP_BYTE = 8'hFF;

  // Result status codes
  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_STOP = 2'd1;
  localparam logic [1:0] STATUS_CSUM = 2'd2;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLES    = 1'd1;
  localparam logic [15:0] BATT_MIN_RESET = 16'd6000;
  localparam logic [7:0]  POLES_RESET    = 8'd62;

  // Scaling constants
  localparam logic [16:0] VOLT_CAL   = 17'd100;
  localparam logic [15:0] NTC_LIMIT  = 16'd4096;
  localparam logic [12:0] NTC_FULL   = 13'd4096;
  // Divide a 16-bit raw value by 100: multiply by ceil(2^23 / 100), keep bits from 23 up
  localparam logic [16:0] PCT_RECIP  = 17'd83887;
  localparam int          PCT_SHIFT  = 23;

  // Shared multiplier and divider widths
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 50;
  localparam int DEN_W     = 36;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Temperature fixed point
  localparam int LOGY_W = 31;
  localparam int LOG_W  = 20;
  localparam int LQ_W   = 22;
  localparam logic signed [MUL_W-1:0] LN2_Q16  = 33'sd45426;
  localparam logic signed [MUL_W-1:0] NTC_BETA = 33'sd29815;
  localparam logic signed [PROD_W-1:0] DEN_BIAS = 66'sd22642688000;
  localparam logic signed [PROD_W-1:0] LQ_ROUND = 66'sd65535;
  localparam logic [DIV_W-1:0] TK_NUM   = DIV_W'(64'd10301082500 << 16);
  localparam logic [DIV_W-1:0] TK_ZERO  = DIV_W'(27315);
  localparam logic [DIV_W-1:0] TK_MAX   = DIV_W'(47315);

  typedef struct packed {
    logic [FRAME_LEN-1:0][7:0] bytes;
    logic [7:0]                sum_lo;
    logic [7:0]                sum_hi;
  } frame_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic [16:0]        voltage_centivolts;
    logic               voltage_usable;
    logic [14:0]        temperature_centidegrees;
    logic [18:0]        current_centiamps;
    logic [35:0]        power_product;
    logic signed [31:0] mechanical_rpm;
    logic [9:0]         throttle_percent;
    logic [9:0]         motor_duty_percent;
    logic [7:0]         esc_status_flags;
  } result_t;

  // Index of the highest set bit of a 12-bit value
  function automatic logic [3:0] msb12(input logic [11:0] n);
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < 12; i++) begin
      if (n[i]) m = 4'(i);
    end
    return m;
  endfunction

endpackage

/* sv/efp_if.sv */
// Handshake channels of the telemetry frame parser: byte input, result output, config write.
// Depends on efp_pkg for widths.
`timescale 1ns / 1ps

interface efp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source(output valid, data_byte, frame_start, input ready);
  modport sink(input valid, data_byte, frame_start, output ready);
endinterface

interface efp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [16:0]        voltage_centivolts;
  logic               voltage_usable;
  logic [14:0]        temperature_centidegrees;
  logic [18:0]        current_centiamps;
  logic [35:0]        power_product;
  logic signed [31:0] mechanical_rpm;
  logic [9:0]         throttle_percent;
  logic [9:0]         motor_duty_percent;
  logic [7:0]         esc_status_flags;
  modport source(output valid, frame_status, voltage_centivolts, voltage_usable,
                 temperature_centidegrees, current_centiamps, power_product,
                 mechanical_rpm, throttle_percent, motor_duty_percent,
                 esc_status_flags, input ready);
  modport sink(input valid, frame_status, voltage_centivolts, voltage_usable,
               temperature_centidegrees, current_centiamps, power_product,
               mechanical_rpm, throttle_percent, motor_duty_percent,
               esc_status_flags, output ready);
endinterface

interface efp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [efp_pkg::CFG_IDX_W-1:0]    index;
  logic [efp_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/efp_frame.sv */
// Byte capture for the telemetry frame parser: position, Fletcher-16 sums, frame store.
// Depends on efp_pkg.
`timescale 1ns / 1ps

module efp_frame (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            frame_start,
  output efp_pkg::frame_t frame,
  output logic            last
);

  logic [efp_pkg::POS_W-1:0]                 byte_position;
  logic [7:0]                                sum_lo;
  logic [7:0]                                sum_hi;
  logic [efp_pkg::FRAME_LEN-1:0][7:0]        store;
  logic [efp_pkg::POS_W-1:0]                 pos;
  logic [7:0]                                lo_base;
  logic [7:0]                                hi_base;
  logic [8:0]                                lo_sum;
  logic [8:0]                                hi_sum;
  logic [7:0]                                sum_lo_next;
  logic [7:0]                                sum_hi_next;

  // Position and running sums for the byte on the input
  always_comb begin
    pos         = frame_start ? '0 : byte_position;
    lo_base     = (pos == '0) ? 8'd0 : sum_lo;
    hi_base     = (pos == '0) ? 8'd0 : sum_hi;
    lo_sum      = {1'b0, lo_base} + {1'b0, data_byte};
    sum_lo_next = (lo_sum >= 9'd255) ? 8'(lo_sum - 9'd255) : lo_sum[7:0];
    hi_sum      = {1'b0, hi_base} + {1'b0, sum_lo_next};
    sum_hi_next = (hi_sum >= 9'd255) ? 8'(hi_sum - 9'd255) : hi_sum[7:0];
    last        = accept && (pos == efp_pkg::POS_LAST);
  end

  // Advance the position on each accepted byte, and the sums only below the checksum position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      sum_lo        <= '0;
      sum_hi        <= '0;
    end else if (accept) begin
      byte_position <= (pos == efp_pkg::POS_LAST) ? '0 : pos + 1'b1;
      if (pos < efp_pkg::POS_SUM) begin
        sum_lo <= sum_lo_next;
        sum_hi <= sum_hi_next;
      end else begin
        sum_lo <= lo_base;
        sum_hi <= hi_base;
      end
    end
  end

  // Store the byte at its position
  always_ff @(posedge clk) begin
    if (accept) begin
      store[pos] <= data_byte;
    end
  end

  assign frame.bytes  = store;
  assign frame.sum_lo = sum_lo;
  assign frame.sum_hi = sum_hi;

endmodule

/* sv/efp_mul.sv */
// Shared signed multiplier with a registered product for the frame-end arithmetic.
// Depends on efp_pkg.
`timescale 1ns / 1ps

module efp_mul (
  input  logic                                clk,
  input  logic signed [efp_pkg::MUL_W-1:0]    a,
  input  logic signed [efp_pkg::MUL_W-1:0]    b,
  output logic signed [efp_pkg::PROD_W-1:0]   p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* sv/efp_div.sv */
// Shared restoring divider, one quotient bit per cycle, for the frame-end arithmetic.
// Depends on efp_pkg.
`timescale 1ns / 1ps

module efp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [efp_pkg::DIV_W-1:0]     dividend,
  input  logic [efp_pkg::DEN_W-1:0]     divisor,
  output logic                          busy,
  output logic [efp_pkg::DIV_W-1:0]     quotient,
  output logic [efp_pkg::DEN_W-1:0]     remainder
);

  logic [efp_pkg::DIV_CNT_W-1:0] cnt;
  logic [efp_pkg::DEN_W-1:0]     rem;
  logic [efp_pkg::DIV_W-1:0]     dq;
  logic [efp_pkg::DEN_W-1:0]     dsr;
  logic [efp_pkg::DEN_W:0]       trial;
  logic                          fits;

  // Shift in the next dividend bit and compare
  always_comb begin
    trial = {rem, dq[efp_pkg::DIV_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= efp_pkg::DIV_CNT_W'(efp_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == efp_pkg::DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? efp_pkg::DEN_W'(trial - {1'b0, dsr}) : trial[efp_pkg::DEN_W-1:0];
      dq  <= {dq[efp_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

/* sv/esc_telemetry_frame_parser_unit.sv */
// Telemetry frame parser: 22-byte frames, Fletcher-16 check, scaled telemetry result.
// Bytes that are not the last of a frame are taken back to back.
// The last byte starts the frame-end sequence: 32 squarings on the shared multiplier and two
// divisions on the shared divider for a good frame with a valid temperature, one division with
// no valid temperature, none for an error frame; no byte is taken meanwhile.
// Reset (synchronous) clears position, sums, sequencer and output valid; config gets defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esc_telemetry_frame_parser_unit (
  input  logic       clk,
  input  logic       rst,
  efp_in_if.sink     byte_in,
  efp_out_if.source  result_out,
  efp_cfg_if.sink    cfg_wr
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_PWR, S_LINIT, S_SQ, S_SQW, S_LQ, S_LQW, S_DEN, S_DENW,
    S_TDIV, S_TWAIT, S_RDIV, S_RWAIT, S_THDIV, S_THWAIT, S_DUDIV, S_DUWAIT, S_EMIT
  } state_t;

  state_t                                   state;
  logic [15:0]                              batt_min;
  logic [7:0]                               poles;
  efp_pkg::result_t                         work;
  efp_pkg::result_t                         outr;
  logic                                     out_valid;
  logic                                     log_sel;
  logic [efp_pkg::LOGY_W-1:0]               lg_y;
  logic [15:0]                              lg_frac;
  logic [3:0]                               lg_msb;
  logic [3:0]                               lg_bit;
  logic [efp_pkg::LOG_W-1:0]                log_a;
  logic signed [efp_pkg::LQ_W-1:0]          lq;
  logic [efp_pkg::DEN_W-1:0]                den;

  logic                                     byte_acc;
  efp_pkg::frame_t                          frame;
  logic                                     frame_last;

  logic signed [efp_pkg::MUL_W-1:0]         mul_a;
  logic signed [efp_pkg::MUL_W-1:0]         mul_b;
  logic signed [efp_pkg::PROD_W-1:0]        mul_p;
  logic                                     div_start;
  logic [efp_pkg::DIV_W-1:0]                div_dividend;
  logic [efp_pkg::DEN_W-1:0]                div_divisor;
  logic                                     div_busy;
  logic [efp_pkg::DIV_W-1:0]                div_quo;
  logic [efp_pkg::DEN_W-1:0]                div_rem;

  logic [15:0]                              v_raw;
  logic [15:0]                              t_raw;
  logic [15:0]                              thr_raw;
  logic [15:0]                              duty_raw;
  logic [31:0]                              erpm;
  logic [16:0]                              volts;
  logic [18:0]                              amps;
  logic                                     stop_ok;
  logic                                     chk_ok;
  logic                                     temp_ok;
  logic [11:0]                              lg_n;
  logic [3:0]                               msb_n;
  logic [31:0]                              sq;
  logic [15:0]                              lg_frac_next;
  logic signed [20:0]                       log_diff;
  logic signed [efp_pkg::PROD_W-1:0]        lq_full;
  logic signed [efp_pkg::PROD_W-1:0]        den_full;
  logic                                     den_ok;
  logic                                     t_valid;
  logic [31:0]                              rpm_mag;
  logic [7:0]                               pole_eff;

  assign byte_acc       = byte_in.valid && byte_in.ready;
  assign byte_in.ready  = (state == S_IDLE);
  assign cfg_wr.ready   = 1'b1;

  efp_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (byte_acc),
    .data_byte   (byte_in.data_byte),
    .frame_start (byte_in.frame_start),
    .frame       (frame),
    .last        (frame_last)
  );

  efp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  efp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Decode the stored frame
  always_comb begin
    v_raw    = {frame.bytes[1], frame.bytes[0]};
    t_raw    = {frame.bytes[3], frame.bytes[2]};
    thr_raw  = {frame.bytes[13], frame.bytes[12]};
    duty_raw = {frame.bytes[15], frame.bytes[14]};
    erpm     = {frame.bytes[11], frame.bytes[10], frame.bytes[9], frame.bytes[8]};
    volts    = {1'b0, v_raw} + ((v_raw > batt_min) ? efp_pkg::VOLT_CAL : 17'd0);
    amps     = {v_raw[15:0] & 16'h0, 3'b0} | {frame.bytes[5], frame.bytes[4], 3'b0};
    stop_ok  = (frame.bytes[20] == efp_pkg::STOP_BYTE) &&
               (frame.bytes[21] == efp_pkg::STOP_BYTE);
    chk_ok   = ({frame.sum_hi, frame.sum_lo} == {frame.bytes[19], frame.bytes[18]});
    temp_ok  = (t_raw != 16'd0) && (t_raw < efp_pkg::NTC_LIMIT);
    rpm_mag  = erpm[31] ? (~erpm + 32'd1) : erpm;
    pole_eff = (poles == 8'd0) ? 8'd1 : poles;
  end

  // Log2 and temperature intermediates
  always_comb begin
    lg_n         = log_sel ? 12'(efp_pkg::NTC_FULL - {1'b0, t_raw[11:0]}) : t_raw[11:0];
    msb_n        = efp_pkg::msb12(lg_n);
    sq           = mul_p[61:30];
    lg_frac_next = lg_frac | (sq[31] ? (16'd1 << lg_bit) : 16'd0);
    log_diff     = $signed({1'b0, log_a}) - $signed({1'b0, lg_msb, lg_frac});
    lq_full      = mul_p[efp_pkg::PROD_W-1] ? ((mul_p + efp_pkg::LQ_ROUND) >>> 16)
                                            : (mul_p >>> 16);
    den_full     = mul_p + efp_pkg::DEN_BIAS;
    den_ok       = !den_full[efp_pkg::PROD_W-1] && (den_full != '0);
    t_valid      = (div_quo >= efp_pkg::TK_ZERO) && (div_quo < efp_pkg::TK_MAX ||
                   (div_quo == efp_pkg::TK_MAX && div_rem == '0));
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CHECK: begin
        mul_a = $signed({14'b0, amps});
        mul_b = $signed({16'b0, volts});
      end
      S_SQ: begin
        mul_a = $signed({2'b0, lg_y});
        mul_b = $signed({2'b0, lg_y});
      end
      S_LQ: begin
        mul_a = efp_pkg::MUL_W'(log_diff);
        mul_b = efp_pkg::LN2_Q16;
      end
      S_DEN: begin
        mul_a = efp_pkg::MUL_W'(lq);
        mul_b = efp_pkg::NTC_BETA;
      end
      S_THDIV: begin
        mul_a = $signed({17'b0, thr_raw});
        mul_b = $signed({16'b0, efp_pkg::PCT_RECIP});
      end
      S_DUDIV: begin
        mul_a = $signed({17'b0, duty_raw});
        mul_b = $signed({16'b0, efp_pkg::PCT_RECIP});
      end
      default: ;
    endcase
  end

  // Select divider operands
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_TDIV: begin
        div_start    = 1'b1;
        div_dividend = efp_pkg::TK_NUM;
        div_divisor  = den;
      end
      S_RDIV: begin
        div_start    = 1'b1;
        div_dividend = efp_pkg::DIV_W'(rpm_mag);
        div_divisor  = efp_pkg::DEN_W'(pole_eff);
      end
      default: ;
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      batt_min <= efp_pkg::BATT_MIN_RESET;
      poles    <= efp_pkg::POLES_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        efp_pkg::CFG_BATT_MIN: batt_min <= cfg_wr.data;
        efp_pkg::CFG_POLES:    poles    <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

  // Frame-end sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result_out.ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (byte_acc && frame_last) state <= S_CHECK;
        end
        S_CHECK: begin
          if (!stop_ok) begin
            work  <= '{frame_status: efp_pkg::STATUS_STOP, default: '0};
            state <= S_EMIT;
          end else if (!chk_ok) begin
            work  <= '{frame_status: efp_pkg::STATUS_CSUM, default: '0};
            state <= S_EMIT;
          end else begin
            work  <= '{frame_status:       efp_pkg::STATUS_GOOD,
                       voltage_centivolts: volts,
                       voltage_usable:     volts > efp_pkg::VOLT_CAL,
                       current_centiamps:  amps,
                       esc_status_flags:   frame.bytes[16],
                       default:            '0};
            state <= S_PWR;
          end
        end
        S_PWR: begin
          work.power_product <= mul_p[35:0];
          log_sel            <= 1'b0;
          state              <= temp_ok ? S_LINIT : S_RDIV;
        end
        S_LINIT: begin
          lg_msb  <= msb_n;
          lg_y    <= efp_pkg::LOGY_W'(lg_n) << (5'd30 - {1'b0, msb_n});
          lg_frac <= '0;
          lg_bit  <= 4'd15;
          state   <= S_SQ;
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          lg_y    <= sq[31] ? sq[31:1] : sq[30:0];
          lg_frac <= lg_frac_next;
          if (lg_bit == 4'd0) begin
            if (!log_sel) begin
              log_a   <= {lg_msb, lg_frac_next};
              log_sel <= 1'b1;
              state   <= S_LINIT;
            end else begin
              state <= S_LQ;
            end
          end else begin
            lg_bit <= lg_bit - 4'd1;
            state  <= S_SQ;
          end
        end
        S_LQ: state <= S_LQW;
        S_LQW: begin
          lq    <= lq_full[efp_pkg::LQ_W-1:0];
          state <= S_DEN;
        end
        S_DEN: state <= S_DENW;
        S_DENW: begin
          den   <= den_full[efp_pkg::DEN_W-1:0];
          state <= den_ok ? S_TDIV : S_RDIV;
        end
        S_TDIV: state <= S_TWAIT;
        S_TWAIT: begin
          if (!div_busy) begin
            if (t_valid) begin
              work.temperature_centidegrees <= 15'(div_quo - efp_pkg::TK_ZERO);
            end
            state <= S_RDIV;
          end
        end
        S_RDIV: state <= S_RWAIT;
        S_RWAIT: begin
          if (!div_busy) begin
            work.mechanical_rpm <= erpm[31] ? -$signed(div_quo[31:0])
                                            : $signed(div_quo[31:0]);
            state <= S_THDIV;
          end
        end
        S_THDIV: state <= S_THWAIT;
        // Take the reciprocal product as the quotient by 100
        S_THWAIT: begin
          work.throttle_percent <= mul_p[efp_pkg::PCT_SHIFT +: 10];
          state                 <= S_DUDIV;
        end
        S_DUDIV: state <= S_DUWAIT;
        S_DUWAIT: begin
          work.motor_duty_percent <= mul_p[efp_pkg::PCT_SHIFT +: 10];
          state                   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || result_out.ready) begin
            outr      <= work;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Drive the result channel
  assign result_out.valid                    = out_valid;
  assign result_out.frame_status             = outr.frame_status;
  assign result_out.voltage_centivolts       = outr.voltage_centivolts;
  assign result_out.voltage_usable           = outr.voltage_usable;
  assign result_out.temperature_centidegrees = outr.temperature_centidegrees;
  assign result_out.current_centiamps        = outr.current_centiamps;
  assign result_out.power_product            = outr.power_product;
  assign result_out.mechanical_rpm           = outr.mechanical_rpm;
  assign result_out.throttle_percent         = outr.throttle_percent;
  assign result_out.motor_duty_percent       = outr.motor_duty_percent;
  assign result_out.esc_status_flags         = outr.esc_status_flags;

  // Error results carry no telemetry
  `EFP_ASSERT(a_err_zero, (out_valid && outr.frame_status != efp_pkg::STATUS_GOOD) |-> (outr.power_product == '0 && outr.mechanical_rpm == '0))
  // Bytes are never taken while the divider runs
  `EFP_ASSERT(a_ready_idle, byte_in.ready |-> !div_busy)
  // The last byte of a frame closes the input
  `EFP_ASSERT_NEXT(a_last_hold, byte_acc && frame_last, !byte_in.ready)

endmodule
